/* rtl/hfd_pkg.sv */
// Shared types, constants and command/status structs of the Huffman tree bit decoder.
package hfd_pkg;

  // Sizing of the node store and the code table.
  localparam int MAX_SYMBOLS  = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int NODE_DEPTH   = 2 * MAX_SYMBOLS - 1;
  localparam int IDX_W        = $clog2(NODE_DEPTH + 1);
  localparam int ADDR_W       = $clog2(NODE_DEPTH);
  localparam int SYM_W        = 8;
  localparam int CODE_W       = 32;
  localparam int CODE_IDX_W   = $clog2(CODE_W);
  localparam int LEN_W        = 6;
  localparam int BYTE_W       = 8;
  localparam int BIT_CNT_W    = $clog2(BYTE_W);
  localparam int CMP_W        = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;

  // Operation codes of an input item.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // Input item.
  typedef struct packed {
    logic              op;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [SYM_W-1:0] out_symbol;
    logic             error;
    logic             last;
  } out_item_t;

  // One entry of the node store. A child index of zero means no child.
  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] sym;
    logic [IDX_W-1:0] right;
    logic [IDX_W-1:0] left;
  } node_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic walk_step;
    logic alloc_step;
    logic leaf_write;
    logic prep_read;
    logic dec_step;
    logic dec_chk;
    logic flush;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_op;
    logic len_bad;
    logic walk_go;
    logic fits;
    logic need_zero;
    logic alloc_last;
    logic wp_zero;
    logic dec_err;
    logic bit_last;
    logic emit_ok;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

/* rtl/huffman_tree_bit_decoder.sv */
// Top level of the Huffman tree bit decoder: controller and datapath.
// Load item: accept, a walk step per existing node on the code path, a decision, an allocation
//   step per new node and a leaf write.
// Decode item: accept, a reread of the current node if the walk is off the root, a step per bit
//   that misses a child, a step and a check per bit that reaches a node, and a last-result flush.
// One item is in work at a time; the output register lets the next item enter while a result waits.
// Reset is asynchronous and active low; it empties the tree, the node store needs no clearing.
module huffman_tree_bit_decoder import hfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  hfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Node store and result path.
  hfd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

/* rtl/hfd_dp.sv */
// Datapath of the Huffman tree bit decoder: node store, tree registers and result buffering.
module hfd_dp import hfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  cmd_t      cmd_i,
  output sts_t      sts_o
);

  // Node store and its registered read data.
  node_t mem [NODE_DEPTH];
  node_t rdata_q;

  in_item_t         item_q;
  logic [IDX_W-1:0] pos_q;
  logic [LEN_W-1:0] depth_q;
  logic             fresh_q;
  logic [BIT_CNT_W-1:0] bitcnt_q;
  logic [IDX_W-1:0] root_left_q;
  logic [IDX_W-1:0] root_right_q;
  logic [IDX_W-1:0] next_free_q;
  logic [IDX_W-1:0] wp_q;

  // Pending result (held until it is known whether it is the last of its byte).
  logic [SYM_W-1:0] pend_sym_q;
  logic             pend_err_q;
  logic             pend_valid_q;
  logic             out_valid_q;
  out_item_t        out_data_q;

  logic             ld_bit;
  logic [IDX_W-1:0] ld_child;
  logic [CMP_W-1:0] needed;
  logic [CMP_W-1:0] free_cnt;
  logic             dbit;
  logic [IDX_W-1:0] dchild;
  logic             dec_err;
  logic             out_free;
  logic             rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr;
  node_t            wr_data;
  node_t            base;
  logic             res_v;
  logic [SYM_W-1:0] res_sym;
  logic             res_err;
  logic             push;
  out_item_t        push_data;

  // Node k lives at address k-1.
  function automatic logic [ADDR_W-1:0] to_addr(logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] t;
    t = idx - IDX_W'(1);
    return t[ADDR_W-1:0];
  endfunction

  // Load walk: code bit at the current depth and the child it selects.
  always_comb begin
    if (depth_q < LEN_W'(CODE_W)) begin
      ld_bit = item_q.code_bits[depth_q[CODE_IDX_W-1:0]];
    end else begin
      ld_bit = 1'b0;
    end
    if (pos_q == '0) begin
      ld_child = ld_bit ? root_right_q : root_left_q;
    end else begin
      ld_child = ld_bit ? rdata_q.right : rdata_q.left;
    end
  end

  // Free space check for the nodes still to be allocated.
  assign needed   = CMP_W'(item_q.code_length) - CMP_W'(depth_q);
  assign free_cnt = (next_free_q == '0) ? '0
                  : CMP_W'(NODE_DEPTH + 1) - CMP_W'(next_free_q);

  // Decode walk: data bit and the child it selects.
  always_comb begin
    dbit = item_q.data_byte[bitcnt_q];
    if (wp_q == '0) begin
      dchild = dbit ? root_right_q : root_left_q;
    end else begin
      dchild = dbit ? rdata_q.right : rdata_q.left;
    end
    dec_err = (dchild == '0) || (CMP_W'(dchild) > CMP_W'(NODE_DEPTH));
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Status towards the controller.
  always_comb begin
    sts_o.in_op      = in_data_i.op;
    sts_o.len_bad    = (item_q.code_length == '0) ||
                       (int'(item_q.code_length) > MAX_CODE_LEN);
    sts_o.walk_go    = (depth_q < item_q.code_length) && (ld_child != '0);
    sts_o.fits       = needed <= free_cnt;
    sts_o.need_zero  = depth_q == item_q.code_length;
    sts_o.alloc_last = (CMP_W'(depth_q) + CMP_W'(1)) == CMP_W'(item_q.code_length);
    sts_o.wp_zero    = wp_q == '0;
    sts_o.dec_err    = dec_err;
    sts_o.bit_last   = bitcnt_q == BIT_CNT_W'(BYTE_W - 1);
    sts_o.emit_ok    = !pend_valid_q || out_free;
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = out_free;
  end

  // Memory port control.
  always_comb begin
    base    = fresh_q ? '0 : rdata_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd_i.walk_step) begin
      rd_en   = 1'b1;
      rd_addr = to_addr(ld_child);
    end else if (cmd_i.prep_read) begin
      rd_en   = 1'b1;
      rd_addr = to_addr(wp_q);
    end else if (cmd_i.dec_step && !dec_err) begin
      rd_en   = 1'b1;
      rd_addr = to_addr(dchild);
    end
    wr_en   = 1'b0;
    wr_addr = to_addr(pos_q);
    wr_data = base;
    if (cmd_i.alloc_step && (pos_q != '0)) begin
      wr_en = 1'b1;
      if (ld_bit) begin
        wr_data.right = next_free_q;
      end else begin
        wr_data.left = next_free_q;
      end
    end else if (cmd_i.leaf_write) begin
      wr_en        = 1'b1;
      wr_data.leaf = 1'b1;
      wr_data.sym  = item_q.symbol;
    end
  end

  // Node store.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Result generation and the transfer of the pending result to the output register.
  always_comb begin
    res_v   = 1'b0;
    res_sym = '0;
    res_err = 1'b0;
    if (cmd_i.dec_step && dec_err) begin
      res_v   = 1'b1;
      res_err = 1'b1;
    end else if (cmd_i.dec_chk && rdata_q.leaf) begin
      res_v   = 1'b1;
      res_sym = rdata_q.sym;
    end
    push      = (res_v || cmd_i.flush) && pend_valid_q;
    push_data = '{out_symbol: pend_sym_q, error: pend_err_q, last: cmd_i.flush};
  end

  // Captured item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (res_v) begin
      pend_sym_q <= res_sym;
      pend_err_q <= res_err;
    end
    if (push) begin
      out_data_q <= push_data;
    end
  end

  // Tree, walk and handshake state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      depth_q      <= '0;
      fresh_q      <= 1'b0;
      bitcnt_q     <= '0;
      root_left_q  <= '0;
      root_right_q <= '0;
      next_free_q  <= IDX_W'(1);
      wp_q         <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        pos_q    <= '0;
        depth_q  <= '0;
        fresh_q  <= 1'b0;
        bitcnt_q <= '0;
      end
      if (cmd_i.walk_step) begin
        pos_q   <= ld_child;
        depth_q <= depth_q + LEN_W'(1);
      end
      if (cmd_i.alloc_step) begin
        if (pos_q == '0) begin
          if (ld_bit) begin
            root_right_q <= next_free_q;
          end else begin
            root_left_q <= next_free_q;
          end
        end
        pos_q   <= next_free_q;
        fresh_q <= 1'b1;
        depth_q <= depth_q + LEN_W'(1);
        if (CMP_W'(next_free_q) >= CMP_W'(NODE_DEPTH)) begin
          next_free_q <= '0;
        end else begin
          next_free_q <= next_free_q + IDX_W'(1);
        end
      end
      if (cmd_i.dec_step) begin
        if (dec_err) begin
          wp_q     <= '0;
          bitcnt_q <= bitcnt_q + BIT_CNT_W'(1);
        end else begin
          wp_q <= dchild;
        end
      end
      if (cmd_i.dec_chk) begin
        if (rdata_q.leaf) begin
          wp_q <= '0;
        end
        bitcnt_q <= bitcnt_q + BIT_CNT_W'(1);
      end
      if (res_v) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The final result of a byte is marked last when it is moved out.
  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush && pend_valid_q |=> out_valid_q && out_data_q.last)
    else $error("flushed result not presented as last");

  // An error result carries a zero symbol.
  a_err_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.error |-> out_data_q.out_symbol == '0)
    else $error("error result with nonzero symbol");

  // Allocation only happens while free nodes remain.
  a_alloc_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_step |-> next_free_q != '0)
    else $error("allocation from a full node store");

endmodule

/* rtl/hfd_ctrl.sv */
// Controller state machine of the Huffman tree bit decoder.
module hfd_ctrl import hfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_LEAF  = 3'd3;
  localparam logic [2:0] S_PREP  = 3'd4;
  localparam logic [2:0] S_DSTEP = 3'd5;
  localparam logic [2:0] S_DCHK  = 3'd6;
  localparam logic [2:0] S_FLUSH = 3'd7;

  logic [2:0] state_q;
  logic [2:0] state_d;

  assign in_ready_o = state_q == S_IDLE;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (sts_i.in_op == OP_LOAD) begin
            state_d = S_WALK;
          end else if (sts_i.wp_zero) begin
            state_d = S_DSTEP;
          end else begin
            state_d = S_PREP;
          end
        end
      end
      S_WALK: begin
        if (sts_i.len_bad) begin
          state_d = S_IDLE;
        end else if (sts_i.walk_go) begin
          cmd_o.walk_step = 1'b1;
        end else if (!sts_i.fits) begin
          state_d = S_IDLE;
        end else if (sts_i.need_zero) begin
          state_d = S_LEAF;
        end else begin
          state_d = S_ALLOC;
        end
      end
      S_ALLOC: begin
        cmd_o.alloc_step = 1'b1;
        if (sts_i.alloc_last) begin
          state_d = S_LEAF;
        end
      end
      S_LEAF: begin
        cmd_o.leaf_write = 1'b1;
        state_d          = S_IDLE;
      end
      S_PREP: begin
        cmd_o.prep_read = 1'b1;
        state_d         = S_DSTEP;
      end
      S_DSTEP: begin
        if (sts_i.emit_ok) begin
          cmd_o.dec_step = 1'b1;
          if (!sts_i.dec_err) begin
            state_d = S_DCHK;
          end else if (sts_i.bit_last) begin
            state_d = S_FLUSH;
          end
        end
      end
      S_DCHK: begin
        if (sts_i.emit_ok) begin
          cmd_o.dec_chk = 1'b1;
          state_d       = sts_i.bit_last ? S_FLUSH : S_DSTEP;
        end
      end
      S_FLUSH: begin
        if (!sts_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A decode step that may produce a result only runs when it has room to go.
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.dec_step || cmd_o.dec_chk |-> sts_i.emit_ok)
    else $error("decode step without room for a result");

  // The machine leaves idle only on an input transfer.
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE && !(in_valid_i && in_ready_o) |=> state_q == S_IDLE)
    else $error("left idle without an input transfer");

  // A flush moves a pending result into a free output register.
  a_flush_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.flush |-> sts_i.pend_valid && sts_i.out_free)
    else $error("flush without a pending result or a free output");

endmodule

/* tb/sv/tb_huffman_tree_bit_decoder.sv */
// Self-checking testbench of the Huffman tree bit decoder with a built-in tree predictor.
`timescale 1ns / 100ps

module tb_huffman_tree_bit_decoder;
  import hfd_pkg::*;

  // Keeps a private copy of the code tree and the queue of symbols the block must emit.
  class huffman_scoreboard;
    node_t            nodes[NODE_DEPTH];
    logic [IDX_W-1:0] root_left_q;
    logic [IDX_W-1:0] root_right_q;
    logic [IDX_W-1:0] next_free_q;
    logic [IDX_W-1:0] walk_pos_q;
    out_item_t        expected_symbols[$];
    int               mismatches;
    int               results;
    int               symbols_due;
    int               misses_due;
    int               loads_kept;
    int               loads_dropped;

    function new();
      root_left_q   = '0;
      root_right_q  = '0;
      next_free_q   = IDX_W'(1);
      walk_pos_q    = '0;
      mismatches    = 0;
      results       = 0;
      symbols_due   = 0;
      misses_due    = 0;
      loads_kept    = 0;
      loads_dropped = 0;
    endfunction

    function int free_nodes();
      return (next_free_q == '0) ? 0 : NODE_DEPTH + 1 - int'(next_free_q);
    endfunction

    // Index zero stands for the root, whose children live outside the store.
    function logic [IDX_W-1:0] child_of_node(logic [IDX_W-1:0] idx, logic dir);
      if (idx == '0) return dir ? root_right_q : root_left_q;
      return dir ? nodes[idx - 1].right : nodes[idx - 1].left;
    endfunction

    function void link_child(logic [IDX_W-1:0] idx, logic dir, logic [IDX_W-1:0] kid);
      if (idx == '0) begin
        if (dir) root_right_q = kid;
        else root_left_q = kid;
      end else if (dir) begin
        nodes[idx - 1].right = kid;
      end else begin
        nodes[idx - 1].left = kid;
      end
    endfunction

    // Inserts one code; the whole load is dropped when the free nodes do not suffice.
    function void insert_code(in_item_t it);
      logic [IDX_W-1:0] pos;
      logic [IDX_W-1:0] n;
      int               depth;
      int               len;
      len   = int'(it.code_length);
      pos   = '0;
      depth = 0;
      if (len == 0 || len > MAX_CODE_LEN) return;
      while (depth < len && child_of_node(pos, it.code_bits[depth]) != '0) begin
        pos = child_of_node(pos, it.code_bits[depth]);
        depth++;
      end
      if (len - depth > free_nodes()) begin
        loads_dropped++;
        return;
      end
      for (int i = depth; i < len; i++) begin
        n = next_free_q;
        nodes[n - 1] = '0;
        link_child(pos, it.code_bits[i], n);
        pos = n;
        next_free_q = (n == NODE_DEPTH) ? '0 : n + 1'b1;
      end
      nodes[pos - 1].leaf = 1'b1;
      nodes[pos - 1].sym  = it.symbol;
      loads_kept++;
    endfunction

    // Walks one byte, least significant bit first, from the position left by the last byte.
    function void walk_byte(logic [BYTE_W-1:0] b);
      logic [IDX_W-1:0] c;
      out_item_t        r;
      int               n;
      n = 0;
      for (int i = 0; i < BYTE_W; i++) begin
        c = child_of_node(walk_pos_q, b[i]);
        r = '0;
        if (c == '0) begin
          r.error = 1'b1;
          expected_symbols.push_back(r);
          misses_due++;
          n++;
          walk_pos_q = '0;
        end else if (nodes[c - 1].leaf) begin
          r.out_symbol = nodes[c - 1].sym;
          expected_symbols.push_back(r);
          symbols_due++;
          n++;
          walk_pos_q = '0;
        end else begin
          walk_pos_q = c;
        end
      end
      if (n > 0) begin
        r = expected_symbols.pop_back();
        r.last = 1'b1;
        expected_symbols.push_back(r);
      end
    endfunction

    function void note_input(in_item_t it);
      if (it.op == OP_LOAD) insert_code(it);
      else walk_byte(it.data_byte);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      results++;
      if (expected_symbols.size() == 0) begin
        $display("%0t: unexpected result, got symbol %h error %b last %b",
                 $time, got.out_symbol, got.error, got.last);
        mismatches++;
        return;
      end
      exp_r = expected_symbols.pop_front();
      if (got.out_symbol !== exp_r.out_symbol) begin
        $display("%0t: symbol mismatch, expected %h, got %h",
                 $time, exp_r.out_symbol, got.out_symbol);
        mismatches++;
      end
      if (got.error !== exp_r.error) begin
        $display("%0t: error flag mismatch, expected %b, got %b", $time, exp_r.error, got.error);
        mismatches++;
      end
      if (got.last !== exp_r.last) begin
        $display("%0t: last flag mismatch, expected %b, got %b", $time, exp_r.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  localparam int RANDOM_ITEMS = 380;
  localparam int HEAVY_PCT    = 87;
  localparam int LIGHT_PCT    = 11;
  localparam int PHASE_ITEMS  = 40;
  localparam int SETTLE_CYCLES = 40;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  huffman_scoreboard sb = new();

  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               items_sent = 0;
  logic [CODE_W-1:0] known_bits[$];
  int               known_len[$];
  bit               msg_bits[$];

  huffman_tree_bit_decoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #5 clk_i = ~clk_i;

  // Result side: check each transfer, then pick the ready level for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic set_idle_mode(input idle_mode_e m);
    case (m)
      IDLE_SENDER: begin
        send_idle_pct  = HEAVY_PCT;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = HEAVY_PCT;
      end
      IDLE_BOTH: begin
        send_idle_pct  = LIGHT_PCT;
        recv_stall_pct = LIGHT_PCT;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // Holds valid and the payload until the transfer, then hands the item to the predictor.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic load_entry(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] bits,
                            input int len);
    in_item_t it;
    it.op          = OP_LOAD;
    it.symbol      = sym;
    it.code_bits   = bits;
    it.code_length = len[LEN_W-1:0];
    it.data_byte   = BYTE_W'($urandom);
    send_item(it);
    if (len >= 1 && len <= MAX_CODE_LEN) begin
      known_bits.push_back(bits);
      known_len.push_back(len);
    end
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    in_item_t it;
    it.op          = OP_DECODE;
    it.symbol      = SYM_W'($urandom);
    it.code_bits   = CODE_W'($urandom);
    it.code_length = LEN_W'($urandom);
    it.data_byte   = b;
    send_item(it);
  endtask

  // Sender pauses with valid low until every expected symbol has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_symbols.size() != 0) @(posedge clk_i);
  endtask

  // Mostly short codes so that decoding finds leaves; a few long ones go deep.
  function automatic int random_len();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(8, 1);
    if (r < 95) return $urandom_range(16, 9);
    return $urandom_range(32, 17);
  endfunction

  // Either a fresh random code or a prefix of a known one, which can end on an inner node.
  task automatic random_load();
    int               k;
    int               len;
    logic [CODE_W-1:0] bits;
    if (known_len.size() > 0 && $urandom_range(4) == 0) begin
      k    = $urandom_range(known_len.size() - 1);
      bits = known_bits[k];
      len  = $urandom_range(known_len[k], 1);
    end else begin
      bits = CODE_W'($urandom);
      len  = random_len();
    end
    load_entry(SYM_W'($urandom), bits, len);
  endtask

  // Concatenates known codes into a bit stream and sends every whole byte of it.
  task automatic send_message(input int n_codes);
    int                k;
    logic [BYTE_W-1:0] b;
    repeat (n_codes) begin
      k = $urandom_range(known_len.size() - 1);
      for (int i = 0; i < known_len[k]; i++) msg_bits.push_back(known_bits[k][i]);
    end
    while (msg_bits.size() >= BYTE_W) begin
      for (int i = 0; i < BYTE_W; i++) b[i] = msg_bits.pop_front();
      decode_byte(b);
    end
  endtask

  task automatic random_step();
    int r;
    r = $urandom_range(99);
    if (r < 30) begin
      random_load();
    end else if (r < 80 && known_len.size() > 0) begin
      send_message($urandom_range(3, 1));
    end else if (r < 92) begin
      decode_byte(BYTE_W'($urandom));
    end else if (r < 96) begin
      load_entry(SYM_W'($urandom), CODE_W'($urandom), $urandom_range(63, MAX_CODE_LEN + 1));
    end else begin
      load_entry(SYM_W'($urandom), CODE_W'($urandom), 0);
    end
  endtask

  // Main sequence: reset, directed cases, random phases, filling the store, drain.
  initial begin
    int phase_end;
    int target;
    int guard;
    set_idle_mode(IDLE_NONE);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty tree: every bit misses.
    decode_byte(8'h00);
    decode_byte(8'hFF);
    // Empty and overlong codes leave the tree alone.
    load_entry(8'h11, 32'h0000_0000, 0);
    load_entry(8'h12, 32'hFFFF_FFFF, MAX_CODE_LEN + 1);
    load_entry(8'h13, 32'hFFFF_FFFF, 63);
    // Leaf under the root, then a code that runs on through that leaf.
    load_entry(8'h41, 32'h0000_0000, 1);
    load_entry(8'h42, 32'h0000_0002, 2);
    // A code that ends on an inner node turns it into a leaf.
    load_entry(8'h43, 32'h0000_0007, 3);
    load_entry(8'h44, 32'h0000_0003, 2);
    // Longest codes, through existing leaves and inner nodes.
    load_entry(8'hFF, 32'hFFFF_FFFF, MAX_CODE_LEN);
    load_entry(8'h00, 32'hAAAA_AAAA, MAX_CODE_LEN);
    load_entry(8'h80, 32'h0000_0005, 4);
    decode_byte(8'h00);
    decode_byte(8'hFF);
    decode_byte(8'h55);
    decode_byte(8'hAA);
    decode_byte(8'h0F);
    decode_byte(8'hF0);
    decode_byte(8'h5A);
    wait_drained();

    // Random phases, each with its own idling pattern, drained at the end.
    target = items_sent + RANDOM_ITEMS;
    for (int ph = 0; items_sent < target; ph++) begin
      set_idle_mode(idle_mode_e'(ph % 4));
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) random_step();
      wait_drained();
    end

    // Fill the node store to the last entry, then try codes that cannot fit.
    set_idle_mode(IDLE_BOTH);
    guard = 0;
    while (sb.free_nodes() > 0 && guard < 60) begin
      load_entry(SYM_W'($urandom), CODE_W'($urandom), (sb.free_nodes() > MAX_CODE_LEN) ?
                 MAX_CODE_LEN : $urandom_range(MAX_CODE_LEN, 1));
      guard++;
    end
    load_entry(SYM_W'($urandom), CODE_W'($urandom), MAX_CODE_LEN);
    load_entry(SYM_W'($urandom), CODE_W'($urandom), MAX_CODE_LEN);
    random_load();
    set_idle_mode(IDLE_NONE);
    repeat (30) random_step();

    wait_drained();
    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d items: %0d code loads kept, %0d dropped for lack of free nodes.",
             items_sent, sb.loads_kept, sb.loads_dropped);
    $display("Checked %0d results: %0d decoded symbols and %0d missing-child errors.",
             sb.results, sb.symbols_due, sb.misses_due);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog for a block that stops moving.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still expected.", sb.expected_symbols.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/hfd_pkg.sv
rtl/hfd_dp.sv
rtl/hfd_ctrl.sv
rtl/huffman_tree_bit_decoder.sv
tb/sv/tb_huffman_tree_bit_decoder.sv
